/* design/npc_pkg.sv */
package npc_pkg;

    localparam int CH_W    = 8;
    localparam int ENTRY_W = 3 * CH_W;
    localparam int SQ_W    = 2 * CH_W;
    localparam int DIST_W  = 18;
    localparam int IDX_W   = 8;
    localparam int SIZE_W  = 9;
    localparam int NUM_CH  = 3;

    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  entry_index;
        logic [CH_W-1:0]   blue;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   red;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  closest_index;
        logic [DIST_W-1:0] best_distance_sq;
    } result_t;

    // sideband that travels with each palette entry down the chain
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

endpackage

/* design/npc_cell.sv */
module npc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [npc_pkg::CH_W-1:0]    tgt,
    input  npc_pkg::tag_t             tag_in,
    input  logic [npc_pkg::ENTRY_W-1:0] entry_in,
    input  logic [npc_pkg::DIST_W-1:0]  sum_in,
    output npc_pkg::tag_t             tag_out,
    output logic [npc_pkg::ENTRY_W-1:0] entry_out,
    output logic [npc_pkg::DIST_W-1:0]  sum_out
);
    import npc_pkg::*;

    logic [CH_W-1:0]    tgt_reg;
    tag_t               tag_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;
    logic [DIST_W-1:0]  sum_reg;
    logic [DIST_W-1:0]  sum_next;
    logic [CH_W-1:0]    chan;
    logic [CH_W-1:0]    diff;
    logic [SQ_W-1:0]    sq;

    // take the low channel, square its distance to the target, add it on
    always_comb
    begin
        chan       = entry_in[CH_W-1:0];
        diff       = (chan > tgt_reg) ? (chan - tgt_reg) : (tgt_reg - chan);
        sq         = SQ_W'(diff) * SQ_W'(diff);
        sum_next   = sum_in + DIST_W'(sq);
        entry_next = {{CH_W{1'b0}}, entry_in[ENTRY_W-1:CH_W]};
    end

    // hold this cell's target channel for the whole query
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tgt_reg <= tgt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    // advance the entry and partial sum to the next cell
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        sum_reg   <= sum_next;
    end

    assign tag_out   = tag_reg;
    assign entry_out = entry_reg;
    assign sum_out   = sum_reg;

endmodule

/* design/npc_best.sv */
module npc_best #(
    parameter int AW = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  npc_pkg::tag_t            tag_in,
    input  logic [npc_pkg::DIST_W-1:0] dist_in,
    output logic                     done,
    output npc_pkg::result_t         result
);
    import npc_pkg::*;

    logic [AW-1:0]     cnt_reg;
    logic [AW-1:0]     cnt_next;
    logic [AW-1:0]     best_i_reg;
    logic [DIST_W-1:0] best_d_reg;
    logic              done_reg;
    logic              take;

    // entries arrive in index order, so count them to recover the index
    always_comb
    begin
        cnt_next = tag_in.first ? '0 : cnt_reg + AW'(1);
        take     = tag_in.valid && (tag_in.first || (dist_in <= best_d_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag_in.valid && tag_in.last;
            if (tag_in.valid)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // keep the running minimum, later index wins on a tie
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_d_reg <= dist_in;
            best_i_reg <= cnt_next;
        end
    end

    assign done                    = done_reg;
    assign result.closest_index    = IDX_W'(best_i_reg);
    assign result.best_distance_sq = best_d_reg;

endmodule

/* design/nearest_palette_color_top.sv */
// channel  | signals                     | handshake
// ---------+-----------------------------+------------------------------------
// command  | start, busy, cmd            | taken when start && !busy
// config   | cfg_valid, cfg_ready, cfg_data | taken when cfg_valid && cfg_ready
// result   | done, result                | one-cycle strobe, no back-pressure
//
// A palette write never raises busy.
// A query of n entries (n = palette_size clamped to 1..PALETTE_DEPTH) holds
// busy while it makes one palette read per cycle, then while the memory read
// stage, three channel cells and the minimum stage drain. done strobes in the
// cycle busy falls. Reset clears control only; palette entries are undefined
// until written. The receiver cannot stall the result.
module nearest_palette_color_top #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  npc_pkg::cmd_t               cmd,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [npc_pkg::SIZE_W-1:0]  cfg_data,
    output logic                        done,
    output npc_pkg::result_t            result
);
    import npc_pkg::*;

    localparam int AW  = $clog2(PALETTE_DEPTH);
    localparam int CW  = $clog2(PALETTE_DEPTH + 1);
    localparam int SW  = (CW > SIZE_W) ? CW : SIZE_W;

    logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];

    state_t             state_reg;
    state_t             state_next;
    logic [SIZE_W-1:0]  size_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      addr_next;
    logic [AW-1:0]      last_reg;
    logic [AW-1:0]      last_next;
    logic [ENTRY_W-1:0] rd_data_reg;
    tag_t               tag0_reg;
    tag_t               issue_tag;

    logic               accept;
    logic               wr_en;
    logic               query;
    logic               issue;
    logic [SW-1:0]      size_ext;
    logic [SW-1:0]      count;

    tag_t               tag_c   [NUM_CH+1];
    logic [ENTRY_W-1:0] entry_c [NUM_CH+1];
    logic [DIST_W-1:0]  sum_c   [NUM_CH+1];
    logic [CH_W-1:0]    tgt_c   [NUM_CH];

    assign accept    = start && !busy;
    assign query     = accept && (cmd.mode == MODE_QUERY);
    assign wr_en     = accept && (cmd.mode == MODE_WRITE)
                       && (32'(cmd.entry_index) < 32'(PALETTE_DEPTH));
    assign cfg_ready = 1'b1;

    // clamp the search length to 1..PALETTE_DEPTH
    always_comb
    begin
        size_ext = SW'(size_reg);
        if (size_reg == '0)
        begin
            count = SW'(1);
        end
        else if (size_ext > SW'(PALETTE_DEPTH))
        begin
            count = SW'(PALETTE_DEPTH);
        end
        else
        begin
            count = size_ext;
        end
        last_next = AW'(count - SW'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (tag_c[NUM_CH].valid && tag_c[NUM_CH].last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy            = 1'b1;
        issue           = 1'b0;
        addr_next       = addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                addr_next = '0;
            end
            ST_SCAN:
            begin
                issue     = 1'b1;
                addr_next = addr_reg + AW'(1);
            end
            ST_DRAIN:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
        issue_tag.valid = issue;
        issue_tag.first = issue && (addr_reg == '0);
        issue_tag.last  = issue && (addr_reg == last_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= SIZE_W'(1);
            addr_reg  <= '0;
            last_reg  <= '0;
            tag0_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            tag0_reg  <= issue_tag;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
            if (query)
            begin
                last_reg <= last_next;
            end
        end
    end

    // palette store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(cmd.entry_index)] <= {cmd.red, cmd.green, cmd.blue};
        end
        rd_data_reg <= mem[addr_reg];
    end

    assign tag_c[0]   = tag0_reg;
    assign entry_c[0] = rd_data_reg;
    assign sum_c[0]   = '0;
    assign tgt_c[0]   = cmd.blue;
    assign tgt_c[1]   = cmd.green;
    assign tgt_c[2]   = cmd.red;

    // one cell per channel, blue first
    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_cell
        npc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (query),
            .tgt       (tgt_c[i]),
            .tag_in    (tag_c[i]),
            .entry_in  (entry_c[i]),
            .sum_in    (sum_c[i]),
            .tag_out   (tag_c[i+1]),
            .entry_out (entry_c[i+1]),
            .sum_out   (sum_c[i+1])
        );
    end

    npc_best #(
        .AW (AW)
    ) u_best (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_c[NUM_CH]),
        .dist_in (sum_c[NUM_CH]),
        .done    (done),
        .result  (result)
    );

endmodule

/* design/npc_checker.sv */
module npc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input npc_pkg::cmd_t              cmd,
    input logic                       done,
    input npc_pkg::result_t           result
);
    import npc_pkg::*;

    // a result only appears as the query finishes
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a query");

    // the end of a query always delivers its word
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query ended without a result");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.mode == MODE_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.mode == MODE_WRITE) |=> !busy && !done)
        else $error("palette write caused activity");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.best_distance_sq <= MAX_DIST)
        else $error("distance out of range");

endmodule

bind nearest_palette_color_top npc_checker u_npc_checker (.*);
